@@ rtl/oxc_pkg.sv @@
`default_nettype none
package oxc_pkg;

    localparam int MAX_CITIES = 64;
    localparam int IDX_W      = $clog2(MAX_CITIES);
    localparam int CITY_W     = 7;
    localparam int ACTION_W   = 2;
    localparam int START_W    = 6;
    localparam int LEN_W      = 7;
    localparam int POS_W      = 6;
    localparam int ERR_W      = 2;

    localparam logic [CITY_W-1:0] TOUR_RESET = CITY_W'(MAX_CITIES);

    localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN         = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INCOMPLETE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SEGMENT    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_CHILD      = 2'd3;

    typedef struct packed {
        logic              clr;
        logic              set;
        logic [IDX_W-1:0]  clr_idx;
        logic [CITY_W-1:0] city;
        logic [CITY_W-1:0] limit;
    } t_used_req;

endpackage
`default_nettype wire

@@ rtl/oxc_if.sv @@
`default_nettype none
interface oxc_in_if;
    import oxc_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CITY_W-1:0]   city;
    logic [START_W-1:0]  seg_start;
    logic [LEN_W-1:0]    seg_length;
    modport source (output valid, action, city, seg_start, seg_length, input ready);
    modport sink   (input valid, action, city, seg_start, seg_length, output ready);
endinterface

interface oxc_out_if;
    import oxc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CITY_W-1:0] child_city;
    logic [POS_W-1:0]  position;
    logic              last;
    logic [ERR_W-1:0]  error_code;
    modport source (output valid, child_city, position, last, error_code, input ready);
    modport sink   (input valid, child_city, position, last, error_code, output ready);
endinterface

interface oxc_cfg_if;
    import oxc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CITY_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/oxc_ram.sv @@
`default_nettype none
module oxc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/oxc_used.sv @@
`default_nettype none
module oxc_used (
    input  wire                i_clk,
    input  oxc_pkg::t_used_req i_req,
    output logic               o_ok
);
    import oxc_pkg::*;

    logic              r_used [MAX_CITIES];
    logic              r_hit;
    logic [CITY_W-1:0] city_m1;
    logic [IDX_W-1:0]  idx;
    logic              we;
    logic [IDX_W-1:0]  waddr;

    assign city_m1 = i_req.city - CITY_W'(1);
    assign idx     = city_m1[IDX_W-1:0];
    assign we      = i_req.clr || i_req.set;
    assign waddr   = i_req.clr ? i_req.clr_idx : idx;

    // candidate is in 1..n and not yet in the child
    assign o_ok = (i_req.city != '0) && (i_req.city <= i_req.limit) && !r_hit;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_used[waddr] <= i_req.set;
        end
        r_hit <= r_used[idx];
    end

endmodule
`default_nettype wire

@@ rtl/order_crossover_permutation.sv @@
// Order crossover (OX1) of two city tours.
// i_in carries load and run beats; i_cfg writes tour_length (n, reset 64,
// values above 64 saturate) and is always ready; o_out carries child beats.
// A load beat appends a city to a parent tour; loads
// beyond n cities are dropped. A run beat builds the child, then sends n beats
// in position order, the final one flagged last, or one error beat instead.
// During a run i_in is not ready. The pace of a run is set by the registered
// read ports of the tour RAMs and of the used map and by the one shared city
// check (range and used map) that every candidate city passes through.
// An incomplete-parent or bad-segment run goes straight to its error beat.
// The used map is a one-bit RAM cleared entry by entry at the start of a run.
// Reset empties both parents, sets n to 64 and drops any pending output beat.
// The output beat sits in a register; a stalled receiver holds it, and the
// sequencer waits before loading the next child beat. Load beats are still
// accepted in idle while the last output beat waits.
`default_nettype none
module order_crossover_permutation (
    input  wire       i_clk,
    input  wire       i_rst_n,
    oxc_in_if.sink    i_in,
    oxc_cfg_if.sink   i_cfg,
    oxc_out_if.source o_out
);
    import oxc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CLEAR, S_SEG_RD, S_SEG_LOOK, S_SEG_CHK,
        S_FILL_RD, S_FILL_LOOK, S_FILL_CHK, S_EMIT_RD, S_EMIT_LD, S_ERR
    } t_state;

    t_state             r_state, n_state;
    logic [CITY_W-1:0]  r_tour;
    logic [CITY_W-1:0]  r_fill1, n_fill1;
    logic [CITY_W-1:0]  r_fill2, n_fill2;
    logic [START_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CITY_W-1:0]  r_end, n_end;
    logic [CITY_W-1:0]  r_pos, n_pos;
    logic [CITY_W-1:0]  r_scan, n_scan;
    logic [ERR_W-1:0]   r_err, n_err;
    logic               r_out_valid, n_out_valid;
    logic [CITY_W-1:0]  r_out_city, n_out_city;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic               r_out_last, n_out_last;
    logic [ERR_W-1:0]   r_out_err, n_out_err;

    logic [CITY_W-1:0] n_cities;
    logic [CITY_W-1:0] max_len;
    logic [CITY_W:0]   seg_end;
    logic              seg_bad;
    logic              in_fire;
    logic              out_free;
    logic              in_seg;
    logic              seg_side;

    logic              we1, we2, wec;
    logic [IDX_W-1:0]  raddr1, raddr2, raddrc;
    logic [CITY_W-1:0] rdata1, rdata2, rdatac, wdatac;
    t_used_req         used_req;
    logic              cand_ok;

    assign n_cities = (r_tour > CITY_W'(MAX_CITIES)) ? CITY_W'(MAX_CITIES) : r_tour;
    assign max_len  = (n_cities >= CITY_W'(3)) ? n_cities - CITY_W'(2) : CITY_W'(1);
    assign seg_end  = {2'b00, r_start} + {1'b0, r_len};
    assign seg_bad  = (n_cities == '0) || (r_len == '0) || (r_len > max_len)
                   || (seg_end > {1'b0, n_cities});
    assign in_seg   = (r_pos >= {1'b0, r_start}) && (r_pos < r_end);

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.child_city = r_out_city;
    assign o_out.position   = r_out_pos;
    assign o_out.last       = r_out_last;
    assign o_out.error_code = r_out_err;

    // tour RAM ports
    assign we1      = in_fire && (i_in.action == ACT_LOAD_FIRST) && (r_fill1 < n_cities);
    assign we2      = in_fire && (i_in.action == ACT_LOAD_SECOND) && (r_fill2 < n_cities);
    assign raddr1   = r_pos[IDX_W-1:0];
    assign raddr2   = r_scan[IDX_W-1:0];
    assign raddrc   = r_pos[IDX_W-1:0];
    assign seg_side = (r_state == S_SEG_LOOK) || (r_state == S_SEG_CHK);
    assign wdatac   = seg_side ? rdata1 : rdata2;
    assign wec      = ((r_state == S_SEG_CHK) || (r_state == S_FILL_CHK)) && cand_ok;

    // shared candidate check
    assign used_req.clr     = (r_state == S_CLEAR);
    assign used_req.set     = wec;
    assign used_req.clr_idx = r_pos[IDX_W-1:0];
    assign used_req.city    = wdatac;
    assign used_req.limit   = n_cities;

    oxc_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_first (
        .i_clk(i_clk), .i_we(we1), .i_waddr(r_fill1[IDX_W-1:0]), .i_wdata(i_in.city),
        .i_raddr(raddr1), .o_rdata(rdata1)
    );

    oxc_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_second (
        .i_clk(i_clk), .i_we(we2), .i_waddr(r_fill2[IDX_W-1:0]), .i_wdata(i_in.city),
        .i_raddr(raddr2), .o_rdata(rdata2)
    );

    oxc_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_child (
        .i_clk(i_clk), .i_we(wec), .i_waddr(r_pos[IDX_W-1:0]), .i_wdata(wdatac),
        .i_raddr(raddrc), .o_rdata(rdatac)
    );

    oxc_used u_used (
        .i_clk(i_clk), .i_req(used_req), .o_ok(cand_ok)
    );

    always_comb begin
        n_state     = r_state;
        n_fill1     = r_fill1;
        n_fill2     = r_fill2;
        n_start     = r_start;
        n_len       = r_len;
        n_end       = r_end;
        n_pos       = r_pos;
        n_scan      = r_scan;
        n_err       = r_err;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_city  = r_out_city;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        if (we1) begin
            n_fill1 = r_fill1 + CITY_W'(1);
        end
        if (we2) begin
            n_fill2 = r_fill2 + CITY_W'(1);
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.action == ACT_RUN)) begin
                    n_start = i_in.seg_start;
                    n_len   = i_in.seg_length;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_pos = '0;
                n_end = seg_end[CITY_W-1:0];
                priority if ((r_fill1 < n_cities) || (r_fill2 < n_cities)) begin
                    n_err   = ERR_INCOMPLETE;
                    n_state = S_ERR;
                end else if (seg_bad) begin
                    n_err   = ERR_SEGMENT;
                    n_state = S_ERR;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_pos == n_cities - CITY_W'(1)) begin
                    n_pos   = {1'b0, r_start};
                    n_state = S_SEG_RD;
                end else begin
                    n_pos = r_pos + CITY_W'(1);
                end
            end
            S_SEG_RD: begin
                if (r_pos == r_end) begin
                    n_pos   = '0;
                    n_scan  = '0;
                    n_state = S_FILL_RD;
                end else begin
                    n_state = S_SEG_LOOK;
                end
            end
            S_SEG_LOOK: begin
                n_state = S_SEG_CHK;
            end
            S_SEG_CHK: begin
                if (cand_ok) begin
                    n_pos   = r_pos + CITY_W'(1);
                    n_state = S_SEG_RD;
                end else begin
                    n_err   = ERR_CHILD;
                    n_state = S_ERR;
                end
            end
            S_FILL_RD: begin
                priority if (r_pos == n_cities) begin
                    n_pos   = '0;
                    n_state = S_EMIT_RD;
                end else if (in_seg) begin
                    n_pos = r_pos + CITY_W'(1);
                end else if (r_scan >= n_cities) begin
                    n_err   = ERR_CHILD;
                    n_state = S_ERR;
                end else begin
                    n_state = S_FILL_LOOK;
                end
            end
            S_FILL_LOOK: begin
                n_state = S_FILL_CHK;
            end
            S_FILL_CHK: begin
                if (cand_ok) begin
                    n_pos = r_pos + CITY_W'(1);
                end
                n_scan  = r_scan + CITY_W'(1);
                n_state = S_FILL_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_city  = rdatac;
                    n_out_pos   = r_pos[POS_W-1:0];
                    n_out_last  = (r_pos + CITY_W'(1) == n_cities);
                    n_out_err   = ERR_OK;
                    n_pos       = r_pos + CITY_W'(1);
                    n_state     = n_out_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_city  = '0;
                    n_out_pos   = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tour      <= TOUR_RESET;
            r_fill1     <= '0;
            r_fill2     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill1     <= n_fill1;
            r_fill2     <= n_fill2;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_tour <= i_cfg.data;
            end
        end
        r_start    <= n_start;
        r_len      <= n_len;
        r_end      <= n_end;
        r_pos      <= n_pos;
        r_scan     <= n_scan;
        r_err      <= n_err;
        r_out_city <= n_out_city;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    a_run_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in.action == ACT_RUN) |=> (r_state == S_CHECK))
        else $error("run beat did not start the check step");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG_CHK) |-> (r_pos < r_end) && (r_end <= n_cities))
        else $error("segment position out of range");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL_CHK) |-> (r_scan < n_cities) && (r_pos < n_cities))
        else $error("second parent scan out of range");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR) && out_free |=> r_out_valid && r_out_last
            && (r_out_err != ERR_OK) && (r_state == S_IDLE))
        else $error("error beat malformed");

    a_ok_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LD) && out_free && (r_pos + CITY_W'(1) == n_cities)
            |=> (r_state == S_IDLE) && r_out_last && (r_out_err == ERR_OK))
        else $error("final child beat not flagged");

endmodule
`default_nettype wire

@@ bench/tb_order_crossover_permutation.sv @@
`default_nettype none
module tb_order_crossover_permutation;
    timeunit 1ns;
    timeprecision 1ps;

    import oxc_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_PHASE = 11;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [CITY_W-1:0] child_city;
        logic [POS_W-1:0]  position;
        logic              last;
        logic [ERR_W-1:0]  error_code;
    } t_child_beat;

    class crossover_scoreboard;
        logic [CITY_W-1:0] first_tour[MAX_CITIES];
        logic [CITY_W-1:0] second_tour[MAX_CITIES];
        int                first_count;
        int                second_count;
        logic [CITY_W-1:0] tour_len_reg;
        t_child_beat       child_beats[$];
        int                fail_count;

        function new();
            foreach (first_tour[i]) begin
                first_tour[i]  = '0;
                second_tour[i] = '0;
            end
            first_count  = 0;
            second_count = 0;
            tour_len_reg = TOUR_RESET;
            fail_count   = 0;
        endfunction

        function int cities();
            return (tour_len_reg > MAX_CITIES) ? MAX_CITIES : int'(tour_len_reg);
        endfunction

        function void write_length(logic [CITY_W-1:0] value);
            tour_len_reg = value;
        endfunction

        function void note_input(logic [ACTION_W-1:0] act, logic [CITY_W-1:0] city,
                                 logic [START_W-1:0] seg_start, logic [LEN_W-1:0] seg_len);
            int                n, maxlen, seg_end, i, scan, c;
            bit                used[MAX_CITIES];
            logic [CITY_W-1:0] child[MAX_CITIES];
            logic [ERR_W-1:0]  err;
            t_child_beat       beat;
            n = cities();
            if (act == ACT_LOAD_FIRST) begin
                if (first_count < n) begin
                    first_tour[first_count] = city;
                    first_count++;
                end
            end else if (act == ACT_LOAD_SECOND) begin
                if (second_count < n) begin
                    second_tour[second_count] = city;
                    second_count++;
                end
            end else if (act == ACT_RUN) begin
                foreach (used[k]) used[k] = 1'b0;
                maxlen  = (n >= 3) ? n - 2 : 1;
                seg_end = int'(seg_start) + int'(seg_len);
                err     = ERR_OK;
                if (first_count < n || second_count < n) begin
                    err = ERR_INCOMPLETE;
                end else if (n == 0 || seg_len < 1 || seg_len > maxlen || seg_end > n) begin
                    err = ERR_SEGMENT;
                end else begin
                    for (i = int'(seg_start); i < seg_end && err == ERR_OK; i++) begin
                        c = first_tour[i];
                        if (c < 1 || c > n || used[c - 1]) begin
                            err = ERR_CHILD;
                        end else begin
                            used[c - 1] = 1'b1;
                            child[i]    = first_tour[i];
                        end
                    end
                    scan = 0;
                    for (i = 0; i < n && err == ERR_OK; i++) begin
                        if (i < int'(seg_start) || i >= seg_end) begin
                            while (scan < n && (int'(second_tour[scan]) < 1 ||
                                   int'(second_tour[scan]) > n ||
                                   used[int'(second_tour[scan]) - 1]))
                                scan++;
                            if (scan >= n) begin
                                err = ERR_CHILD;
                            end else begin
                                child[i] = second_tour[scan];
                                used[int'(second_tour[scan]) - 1] = 1'b1;
                                scan++;
                            end
                        end
                    end
                end
                if (err != ERR_OK) begin
                    beat.child_city = '0;
                    beat.position   = '0;
                    beat.last       = 1'b1;
                    beat.error_code = err;
                    child_beats     = {child_beats, beat};
                end else begin
                    for (i = 0; i < n; i++) begin
                        beat.child_city = child[i];
                        beat.position   = POS_W'(i);
                        beat.last       = (i + 1 == n);
                        beat.error_code = ERR_OK;
                        child_beats     = {child_beats, beat};
                    end
                end
            end
        endfunction

        function void check_result(t_child_beat got);
            t_child_beat want;
            if (child_beats.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected beat: city %0d pos %0d last %0b err %0d",
                             got.child_city, got.position, got.last, got.error_code);
                fail_count++;
            end else begin
                want = child_beats.pop_front();
                if (got.child_city !== want.child_city || got.position !== want.position ||
                    got.last !== want.last || got.error_code !== want.error_code) begin
                    if (fail_count < 10) begin
                        $display("mismatch: want city %0d pos %0d last %0b err %0d",
                                 want.child_city, want.position, want.last,
                                 want.error_code);
                        $display("          got  city %0d pos %0d last %0b err %0d",
                                 got.child_city, got.position, got.last, got.error_code);
                    end
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    oxc_in_if  in_if ();
    oxc_cfg_if cfg_if ();
    oxc_out_if out_if ();

    order_crossover_permutation dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    crossover_scoreboard sb;
    bit in_burst;
    bit out_burst;
    bit hold_requested;
    bit placed[2][MAX_CITIES+1];
    int tour_plan[14] = '{8, 12, 2, 16, 24, 32, 10, 40, 48, 56, 64, 64, 127, 100};

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_beat(logic [ACTION_W-1:0] act, int city, int seg_start, int seg_len);
        int                 gap;
        logic [CITY_W-1:0]  city_f;
        logic [START_W-1:0] start_f;
        logic [LEN_W-1:0]   len_f;
        gap     = in_burst ? 0 : $urandom_range(0, 14);
        city_f  = CITY_W'(city);
        start_f = START_W'(seg_start);
        len_f   = LEN_W'(seg_len);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.action     <= act;
        in_if.city       <= city_f;
        in_if.seg_start  <= start_f;
        in_if.seg_length <= len_f;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sb.note_input(act, city_f, start_f, len_f);
    endtask

    task automatic load_city(logic [ACTION_W-1:0] side, int city);
        int count;
        count = (side == ACT_LOAD_FIRST) ? sb.first_count : sb.second_count;
        if (count < sb.cities() && city >= 1)
            placed[side][city] = 1'b1;
        send_beat(side, city, $urandom_range(0, 63), $urandom_range(0, 64));
    endtask

    // mostly a fresh id in range; now and then an id beyond n that becomes
    // valid later, and for the first tour an arbitrary id (duplicates, zero)
    function automatic int pick_city(logic [ACTION_W-1:0] side, int n);
        int pool[$];
        int roll;
        roll = $urandom_range(0, 99);
        if (side == ACT_LOAD_FIRST && roll < 6)
            return $urandom_range(0, MAX_CITIES);
        if (roll < 14)
            for (int v = n + 1; v <= MAX_CITIES; v++)
                if (!placed[side][v]) pool = {pool, v};
        if (pool.size() == 0)
            for (int v = 1; v <= n; v++)
                if (!placed[side][v]) pool = {pool, v};
        if (pool.size() == 0)
            for (int v = n + 1; v <= MAX_CITIES; v++)
                if (!placed[side][v]) pool = {pool, v};
        if (pool.size() == 0)
            return $urandom_range(0, MAX_CITIES);
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    task automatic send_run(int n);
        int maxlen, len, start;
        maxlen = (n >= 3) ? n - 2 : 1;
        if (n > 0 && $urandom_range(0, 99) < 85) begin
            len   = ($urandom_range(0, 3) == 0) ? maxlen : $urandom_range(1, maxlen);
            start = $urandom_range(0, n - len);
        end else if (n > 0 && $urandom_range(0, 1) == 0) begin
            len   = $urandom_range(1, maxlen);
            start = n - len + 1;
        end else begin
            len   = $urandom_range(0, 64);
            start = $urandom_range(0, 63);
        end
        send_beat(ACT_RUN, $urandom_range(0, MAX_CITIES), start, len);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (sb.child_beats.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tour_length(logic [CITY_W-1:0] value);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        sb.write_length(value);
    endtask

    task automatic run_phase(int len_value, int runs);
        int                  n, left, roll;
        logic [ACTION_W-1:0] side;
        write_tour_length(CITY_W'(len_value));
        n    = sb.cities();
        left = runs;
        while (left > 0 || sb.first_count < n || sb.second_count < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                if (sb.first_count >= n && roll < 2)
                    load_city(ACT_LOAD_FIRST, $urandom_range(0, MAX_CITIES));
                else
                    send_beat(ACT_UNUSED, $urandom_range(0, MAX_CITIES),
                              $urandom_range(0, 63), $urandom_range(0, 64));
            end else if (left > 0 && (roll < 12 ||
                         (sb.first_count >= n && sb.second_count >= n))) begin
                send_run(n);
                left--;
            end else begin
                if (sb.first_count >= n)
                    side = ACT_LOAD_SECOND;
                else if (sb.second_count >= n)
                    side = ACT_LOAD_FIRST;
                else
                    side = $urandom_range(0, 1) ? ACT_LOAD_SECOND : ACT_LOAD_FIRST;
                load_city(side, pick_city(side, n));
            end
        end
    endtask

    initial begin : child_sink
        int          stall;
        t_child_beat beat;
        out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_requested) begin
                stall          = HOLD_CYCLES;
                hold_requested = 1'b0;
            end else begin
                stall = out_burst ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
            beat.child_city = out_if.child_city;
            beat.position   = out_if.position;
            beat.last       = out_if.last;
            beat.error_code = out_if.error_code;
            sb.check_result(beat);
        end
    end

    initial begin
        sb = new();
        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.action     <= ACT_LOAD_FIRST;
        in_if.city       <= '0;
        in_if.seg_start  <= '0;
        in_if.seg_length <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty parents, unused action
        send_beat(ACT_RUN, 0, 63, 64);
        send_beat(ACT_UNUSED, 64, 63, 64);

        write_tour_length(0);
        send_beat(ACT_RUN, 0, 0, 1);

        // parents checked before segment; full-tour loads dropped
        write_tour_length(1);
        send_beat(ACT_RUN, 0, 63, 64);
        load_city(ACT_LOAD_FIRST, 1);
        load_city(ACT_LOAD_SECOND, 1);
        load_city(ACT_LOAD_FIRST, 64);
        load_city(ACT_LOAD_SECOND, 0);
        send_beat(ACT_RUN, 0, 0, 1);
        send_beat(ACT_RUN, 0, 0, 0);
        send_beat(ACT_RUN, 0, 1, 1);

        // out-of-range city in second tour is skipped
        write_tour_length(3);
        load_city(ACT_LOAD_FIRST, 3);
        load_city(ACT_LOAD_FIRST, 2);
        load_city(ACT_LOAD_SECOND, 64);
        load_city(ACT_LOAD_SECOND, 2);
        send_beat(ACT_RUN, 64, 1, 1);
        send_beat(ACT_RUN, 0, 0, 1);

        // repeated and out-of-range segment cities, second tour runs dry
        write_tour_length(5);
        load_city(ACT_LOAD_FIRST, 2);
        load_city(ACT_LOAD_FIRST, 64);
        load_city(ACT_LOAD_SECOND, 2);
        load_city(ACT_LOAD_SECOND, 4);
        send_beat(ACT_RUN, 0, 2, 2);
        send_beat(ACT_RUN, 0, 3, 2);
        send_beat(ACT_RUN, 0, 0, 2);

        foreach (tour_plan[p]) begin
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            if (p == HOLD_PHASE) begin
                hold_requested = 1'b1;
                in_burst       = 1'b1;
                out_burst      = 1'b0;
            end
            run_phase(tour_plan[p], (p >= HOLD_PHASE) ? 6 : $urandom_range(2, 4));
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (sb.fail_count == 0 && sb.child_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/oxc_pkg.sv
rtl/oxc_if.sv
rtl/oxc_ram.sv
rtl/oxc_used.sv
rtl/order_crossover_permutation.sv
bench/tb_order_crossover_permutation.sv
